@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("assertion failed");

`endif

@@ rtl/core/crcfa_pkg.sv @@
// ----------------------------------------------------------------------------
// crcfa_pkg
// Shared types, constants and the CRC-16 byte fold for the frame appender.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package crcfa_pkg;

	// reflected CRC-16 polynomial
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [15:0] CRC_INIT = 16'h0000;

	// default depth of the front-to-back queue (power of two, at least 2)
	localparam int QUEUE_DEPTH = 4;

	// configuration port
	localparam int CFG_ADDR_W = 3;
	localparam logic REG_CTRL_IDX = 1'b0;

	// one classified frame byte travelling from front to back
	typedef struct packed {
		logic [7:0]  data;
		logic        frame_end;
		logic        append;
		logic [15:0] crc;
	} crc_item_t;

	// fold one byte into the CRC, least significant bit first
	function automatic logic [15:0] crc_fold_byte(input logic [15:0] crc_in,
		input logic [7:0] byte_in);
		logic [15:0] c;
		logic        mix;
		c = crc_in;
		for (int b = 0; b < 8; b++) begin
			mix = c[0] ^ byte_in[b];
			c = {1'b0, c[15:1]};
			if (mix) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

endpackage

@@ rtl/core/crc16_frame_appender.sv @@
// ----------------------------------------------------------------------------
// crc16_frame_appender
// Byte stream pass-through with a CRC-16/ARC appended after each frame.
// ----------------------------------------------------------------------------
// Input channel: push with data_byte and frame_end; a transfer happens when
// push is high and full is low. Output channel: out_byte and out_last are
// valid while empty is low; a transfer happens when pop is high.
// Every byte comes out unchanged. On a frame's last byte with appending
// enabled, the CRC low byte and then the CRC high byte follow, and out_last
// marks the final byte of the frame. The CRC restarts from zero per frame.
// Throughput: one byte per cycle while pop stays high; after a frame end with
// appending, the output sequencer emits both CRC bytes before the next byte.
// Each input byte passes the queue and then the output register to the ports.
// When the receiver stalls, the output register holds its byte and the
// queue absorbs up to QUEUE_DEPTH bytes before full rises.
// Reset empties the queue and output, clears the CRC, sets append enable.
// Configuration: register 0 at addresses 0 to 3, bit 0 = append enable;
// write it only while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crc16_frame_appender #(
	parameter int QUEUE_DEPTH = crcfa_pkg::QUEUE_DEPTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  logic [7:0]                       data_byte,
	input  logic                             frame_end,
	output logic                             empty,
	input  logic                             pop,
	output logic [7:0]                       out_byte,
	output logic                             out_last,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [crcfa_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);

	logic                 append_enable_q;
	logic                 cfg_wr;
	logic                 reg_hit;
	logic                 enq;
	logic                 deq;
	logic                 queue_full;
	logic                 queue_empty;
	crcfa_pkg::crc_item_t wr_item;
	crcfa_pkg::crc_item_t head;

	// configuration register
	assign pready  = 1'b1;
	assign reg_hit = (paddr[crcfa_pkg::CFG_ADDR_W-1] == crcfa_pkg::REG_CTRL_IDX);
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign prdata  = reg_hit ? {31'b0, append_enable_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			append_enable_q <= 1'b1;
		end else if (cfg_wr && reg_hit) begin
			append_enable_q <= pwdata[0];
		end
	end

	assign full = queue_full;

	crcfa_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.data_byte     (data_byte),
		.frame_end     (frame_end),
		.append_enable (append_enable_q),
		.queue_full    (queue_full),
		.enq           (enq),
		.item          (wr_item)
	);

	crcfa_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.enq     (enq),
		.wr_item (wr_item),
		.deq     (deq),
		.rd_item (head),
		.full    (queue_full),
		.empty   (queue_empty)
	);

	crcfa_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.queue_empty (queue_empty),
		.deq         (deq),
		.pop         (pop),
		.empty       (empty),
		.out_byte    (out_byte),
		.out_last    (out_last)
	);

endmodule

@@ rtl/core/crcfa_front.sv @@
// ----------------------------------------------------------------------------
// crcfa_front
// Accepts frame bytes, keeps the running CRC and classifies each byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crcfa_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic [7:0]           data_byte,
	input  logic                 frame_end,
	input  logic                 append_enable,
	input  logic                 queue_full,
	output logic                 enq,
	output crcfa_pkg::crc_item_t item
);

	logic [15:0] crc_q;
	logic [15:0] crc_next;

	// byte fold over the running crc
	assign crc_next = crcfa_pkg::crc_fold_byte(crc_q, data_byte);
	assign enq      = push && !queue_full;

	// classified entry for the back end
	always_comb begin
		item.data      = data_byte;
		item.frame_end = frame_end;
		item.append    = frame_end && append_enable;
		item.crc       = crc_next;
	end

	// running crc, cleared after each frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= crcfa_pkg::CRC_INIT;
		end else if (enq) begin
			crc_q <= frame_end ? crcfa_pkg::CRC_INIT : crc_next;
		end
	end

endmodule

@@ rtl/core/crcfa_queue.sv @@
// ----------------------------------------------------------------------------
// crcfa_queue
// Small register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module crcfa_queue #(
	parameter int DEPTH = crcfa_pkg::QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 enq,
	input  crcfa_pkg::crc_item_t wr_item,
	input  logic                 deq,
	output crcfa_pkg::crc_item_t rd_item,
	output logic                 full,
	output logic                 empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	crcfa_pkg::crc_item_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_item = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (enq) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (enq) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (deq) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (enq && !deq) begin
				count_q <= count_q + CNT_W'(1);
			end else if (deq && !enq) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	`ASSERT_IMPL(a_no_overflow, enq, !full || deq)
	`ASSERT_IMPL(a_no_underflow, deq, !empty)
	`ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CNT_W'(DEPTH))

endmodule

@@ rtl/core/crcfa_back.sv @@
// ----------------------------------------------------------------------------
// crcfa_back
// Emits each queued byte and, on an appending frame end, the two CRC bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module crcfa_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  crcfa_pkg::crc_item_t head,
	input  logic                 queue_empty,
	output logic                 deq,
	input  logic                 pop,
	output logic                 empty,
	output logic [7:0]           out_byte,
	output logic                 out_last
);

	typedef enum logic [2:0] {
		PH_DATA   = 3'b001,
		PH_CRC_LO = 3'b010,
		PH_CRC_HI = 3'b100
	} phase_t;

	phase_t      phase_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        out_last_q;
	logic [15:0] crc_q;
	logic        load;

	// output slot is free or its transfer completes this cycle
	assign load     = !out_valid_q || pop;
	assign deq      = load && (phase_q == PH_DATA) && !queue_empty;
	assign empty    = !out_valid_q;
	assign out_byte = out_byte_q;
	assign out_last = out_last_q;

	// phase sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_DATA;
			out_valid_q <= 1'b0;
		end else if (load) begin
			unique case (phase_q)
				PH_DATA: begin
					out_valid_q <= !queue_empty;
					if (!queue_empty && head.append) begin
						phase_q <= PH_CRC_LO;
					end
				end
				PH_CRC_LO: begin
					out_valid_q <= 1'b1;
					phase_q     <= PH_CRC_HI;
				end
				PH_CRC_HI: begin
					out_valid_q <= 1'b1;
					phase_q     <= PH_DATA;
				end
				default: begin
					out_valid_q <= 1'b0;
					phase_q     <= PH_DATA;
				end
			endcase
		end
	end

	// output payload and held crc
	always_ff @(posedge clk) begin
		if (deq) begin
			out_byte_q <= head.data;
			out_last_q <= head.frame_end && !head.append;
			crc_q      <= head.crc;
		end else if (load && phase_q == PH_CRC_LO) begin
			out_byte_q <= crc_q[7:0];
			out_last_q <= 1'b0;
		end else if (load && phase_q == PH_CRC_HI) begin
			out_byte_q <= crc_q[15:8];
			out_last_q <= 1'b1;
		end
	end

	`ASSERT_NEXT(a_hi_is_last, load && phase_q == PH_CRC_HI, out_valid_q && out_last_q)
	`ASSERT_NEXT(a_lo_then_hi, load && phase_q == PH_CRC_LO, phase_q == PH_CRC_HI)
	`ASSERT_IMPL(a_no_deq_mid_crc, phase_q != PH_DATA, !deq)

endmodule
